[rtl/dons_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dons_pkg
// Shared constants and types for the orthonormal DCT scaling core.
// ----------------------------------------------------------------------------
package dons_pkg;

	localparam int MAX_RANK_DEF  = 4;
	localparam int SIZE_BITS_DEF = 12;

	// Width of an axis length as written to the configuration registers.
	localparam int SIZE_W = 13;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_RANK    = 3'd0;
	localparam logic [IDX_W-1:0] REG_SIZE0   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SIZE1   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SIZE2   = 3'd3;
	localparam logic [IDX_W-1:0] REG_SIZE3   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ORTHO   = 3'd5;
	localparam logic [IDX_W-1:0] REG_FORWARD = 3'd6;

	typedef struct packed {
		logic        start;
		logic        fwd;
		logic [31:0] x;
	} dons_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] y;
	} dons_rsp_t;

endpackage

[rtl/dons_arith.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dons_arith
// Sequenced fp32 datapath: builds the scale factor axis by axis, takes its
// square root by a two-bit-per-cycle recurrence, then divides the element by
// it one quotient bit per cycle or multiplies it, and rounds the result.
// ----------------------------------------------------------------------------
module dons_arith import dons_pkg::*; #(
	parameter int MAX_RANK = MAX_RANK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dons_req_t           req,
	input  logic [MAX_RANK-1:0] norm,
	input  logic [MAX_RANK-1:0] czero,
	input  logic [SIZE_W-1:0]   size_eff [MAX_RANK],
	input  logic                ack,
	output dons_rsp_t           rsp
);

	localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam logic [AXW-1:0] AX_LAST = AXW'(MAX_RANK - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FACT  = 4'd1;
	localparam logic [3:0] S_FNORM = 4'd2;
	localparam logic [3:0] S_XCLS  = 4'd3;
	localparam logic [3:0] S_XNORM = 4'd4;
	localparam logic [3:0] S_SQRT  = 4'd5;
	localparam logic [3:0] S_SRND  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_PACK  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]          state_q;
	logic [AXW-1:0]      ax_q;
	logic [MAX_RANK-1:0] norm_q, czero_q;
	logic [SIZE_W-1:0]   size_q [MAX_RANK];
	logic                fwd_q;
	logic [31:0]         x_q;
	logic [23:0]         fm_q;
	logic signed [7:0]   fe_q;
	logic [36:0]         prod_q;
	logic [23:0]         mx_q;
	logic signed [10:0]  ex_q;
	logic [49:0]         nsr_q;
	logic [24:0]         root_q;
	logic [27:0]         rem_q;
	logic [23:0]         sm_q;
	logic signed [10:0]  se_q;
	logic [4:0]          cnt_q;
	logic [26:0]         quo_q;
	logic [47:0]         w_q;
	logic signed [10:0]  e2_q;
	logic                stk_q;
	logic [31:0]         y_q;

	// Normalisation of the factor product.
	logic [3:0]  f_sh;
	logic [36:0] f_t, f_mask;
	logic [24:0] f_m;
	logic        f_rb, f_st;
	logic [23:0] f_fm;
	logic [3:0]  f_einc;

	always_comb begin
		f_sh = 4'd0;
		for (int i = 0; i < 14; i++) begin
			if (prod_q[23 + i]) f_sh = 4'(i);
		end
		f_t    = '0;
		f_mask = '0;
		f_rb   = 1'b0;
		f_st   = 1'b0;
		f_m    = {1'b0, prod_q[23:0]};
		if (f_sh != 4'd0) begin
			f_t    = prod_q >> (f_sh - 4'd1);
			f_mask = (37'h1 << (f_sh - 4'd1)) - 37'h1;
			f_rb   = f_t[0];
			f_st   = |(prod_q & f_mask);
			f_m    = {1'b0, f_t[24:1]} + 25'(f_rb & (f_st | f_t[1]));
		end
		if (f_m[24]) begin
			f_fm   = f_m[24:1];
			f_einc = f_sh + 4'd1;
		end else begin
			f_fm   = f_m[23:0];
			f_einc = f_sh;
		end
	end

	// One step of the square-root recurrence.
	logic [27:0] sq_rem2, sq_trial;
	logic        sq_ge;

	always_comb begin
		sq_rem2  = {rem_q[25:0], nsr_q[49:48]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_rem2 >= sq_trial;
	end

	// Rounding of the root.
	logic [24:0] sr_q;

	always_comb begin
		sr_q = {1'b0, root_q[24:1]}
			+ 25'(root_q[0] & ((rem_q != '0) | root_q[1]));
	end

	// One step of the division recurrence.
	logic [25:0] dv_rem;
	logic        dv_ge;
	logic [25:0] dv_rn;
	logic [26:0] dv_quo;

	always_comb begin
		dv_rem = rem_q[25:0];
		dv_ge  = dv_rem >= {2'b0, sm_q};
		dv_rn  = dv_ge ? (dv_rem - {2'b0, sm_q}) : dv_rem;
		dv_quo = {quo_q[25:0], dv_ge};
	end

	// Final rounding and packing, subnormal results included.
	logic [47:0]        pk_w, pk_sft, pk_mask;
	logic signed [10:0] pk_e, pk_be, pk_sh;
	logic [30:0]        pk_base, pk_sum;
	logic [23:0]        pk_m;
	logic               pk_rb, pk_st, pk_lost;
	logic [31:0]        pk_y;

	always_comb begin
		pk_w    = w_q[47] ? w_q : {w_q[46:0], 1'b0};
		pk_e    = w_q[47] ? e2_q : e2_q - 11'sd1;
		pk_be   = pk_e + 11'sd174;
		pk_sh   = 11'sd1 - pk_be;
		pk_sft  = '0;
		pk_mask = '0;
		pk_lost = 1'b0;
		pk_base = '0;
		pk_m    = '0;
		pk_rb   = 1'b0;
		pk_st   = 1'b0;
		if (pk_be >= 11'sd1) begin
			pk_base = {pk_be[7:0] - 8'd1, 23'b0};
			pk_m    = pk_w[47:24];
			pk_rb   = pk_w[23];
			pk_st   = (|pk_w[22:0]) | stk_q;
		end else if (pk_sh < 11'sd26) begin
			pk_sft  = pk_w >> pk_sh[4:0];
			pk_mask = (48'h1 << pk_sh[4:0]) - 48'h1;
			pk_lost = |(pk_w & pk_mask);
			pk_m    = pk_sft[47:24];
			pk_rb   = pk_sft[23];
			pk_st   = (|pk_sft[22:0]) | pk_lost | stk_q;
		end
		pk_sum = pk_base + {7'b0, pk_m} + 31'(pk_rb & (pk_st | pk_m[0]));
		if (pk_be >= 11'sd255) begin
			pk_y = {x_q[31], 8'hFF, 23'b0};
		end else begin
			pk_y = {x_q[31], pk_sum};
		end
	end

	logic [7:0] xc_e;
	assign xc_e = x_q[30:23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) state_q <= S_FACT;
				end
				S_FACT: begin
					if (norm_q[ax_q]) state_q <= S_FNORM;
					else if (ax_q == AX_LAST) state_q <= S_XCLS;
				end
				S_FNORM: begin
					state_q <= (ax_q == AX_LAST) ? S_XCLS : S_FACT;
				end
				S_XCLS: begin
					if (xc_e == 8'hFF || x_q[30:0] == '0) state_q <= S_DONE;
					else state_q <= S_XNORM;
				end
				S_XNORM: begin
					if (mx_q[23]) state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == 5'd24) state_q <= S_SRND;
				end
				S_SRND: begin
					state_q <= fwd_q ? S_DIV : S_MUL;
				end
				S_DIV: begin
					if (cnt_q == 5'd26) state_q <= S_PACK;
				end
				S_MUL: begin
					state_q <= S_PACK;
				end
				S_PACK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				norm_q  <= norm;
				czero_q <= czero;
				size_q  <= size_eff;
				fwd_q   <= req.fwd;
				x_q     <= req.x;
				fm_q    <= 24'h800000;
				fe_q    <= -8'sd23;
				ax_q    <= '0;
			end
			S_FACT: begin
				if (norm_q[ax_q]) begin
					prod_q <= {13'b0, fm_q} * {24'b0, size_q[ax_q]};
					fe_q   <= fe_q + (czero_q[ax_q] ? 8'sd2 : 8'sd1);
				end else if (ax_q != AX_LAST) begin
					ax_q <= ax_q + 1'b1;
				end
			end
			S_FNORM: begin
				fm_q <= f_fm;
				fe_q <= fe_q + 8'(f_einc);
				if (ax_q != AX_LAST) ax_q <= ax_q + 1'b1;
			end
			S_XCLS: begin
				// NaN is quietened; infinities and zeros pass unchanged.
				if (xc_e == 8'hFF && x_q[22:0] != '0) y_q <= x_q | 32'h0040_0000;
				else y_q <= x_q;
				if (xc_e == 8'd0) begin
					mx_q <= {1'b0, x_q[22:0]};
					ex_q <= -11'sd149;
				end else begin
					mx_q <= {1'b1, x_q[22:0]};
					ex_q <= $signed({3'b0, xc_e}) - 11'sd150;
				end
			end
			S_XNORM: begin
				if (mx_q[23]) begin
					// Even exponent so that the root has exactly 25 bits.
					if (fe_q[0]) begin
						nsr_q <= {1'b0, fm_q, 25'b0};
						se_q  <= 11'((fe_q - 8'sd25) >>> 1) + 11'sd1;
					end else begin
						nsr_q <= {fm_q, 26'b0};
						se_q  <= 11'((fe_q - 8'sd26) >>> 1) + 11'sd1;
					end
					root_q <= '0;
					rem_q  <= '0;
					cnt_q  <= '0;
				end else begin
					mx_q <= {mx_q[22:0], 1'b0};
					ex_q <= ex_q - 11'sd1;
				end
			end
			S_SQRT: begin
				rem_q  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
				root_q <= {root_q[23:0], sq_ge};
				nsr_q  <= {nsr_q[47:0], 2'b00};
				cnt_q  <= cnt_q + 5'd1;
			end
			S_SRND: begin
				sm_q  <= sr_q[24] ? 24'h800000 : sr_q[23:0];
				se_q  <= se_q + 11'(sr_q[24]);
				rem_q <= {4'b0, mx_q};
				quo_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= {1'b0, dv_rn, 1'b0};
				quo_q <= dv_quo;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd26) begin
					w_q   <= {dv_quo, 21'b0};
					e2_q  <= ex_q - se_q - 11'sd47;
					stk_q <= dv_rn != '0;
				end
			end
			S_MUL: begin
				w_q   <= {24'b0, mx_q} * {24'b0, sm_q};
				e2_q  <= ex_q + se_q;
				stk_q <= 1'b0;
			end
			S_PACK: begin
				y_q <= pk_y;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == S_DONE);
	assign rsp.y    = y_q;

endmodule

[rtl/dct_ortho_normalize_scaler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_ortho_normalize_scaler_core
// Scales a row-major stream of fp32 tensor elements for orthonormal DCT use.
// ----------------------------------------------------------------------------
// One element is worked on at a time, and sample_stall stays high until its
// result has moved into the output register. The factor is built axis by
// axis, a subnormal input is normalised, a square-root recurrence runs, then
// a division recurrence in forward mode or one multiply otherwise, and a
// rounding step. NaN, infinite and zero elements skip the arithmetic. The
// finished result waits in the output register, so the next element can be
// accepted while it is still stalled.
module dct_ortho_normalize_scaler_core import dons_pkg::*; #(
	parameter int MAX_RANK  = MAX_RANK_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  logic [31:0]      sample_in,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [31:0]      sample_out,
	output logic             tensor_end,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(1 << SIZE_BITS);

	logic [2:0]          rank_q;
	logic [SIZE_W-1:0]   size_q [4];
	logic [3:0]          ortho_q;
	logic                fwd_q;
	logic [SIZE_BITS-1:0] coord_q [MAX_RANK];
	logic                busy_q;
	logic                tend_q;
	logic                res_valid_q;
	logic [31:0]         sample_out_q;
	logic                tensor_end_q;

	logic [2:0]          rank_eff;
	logic [SIZE_W-1:0]   size_eff [MAX_RANK];
	logic [MAX_RANK-1:0] used, norm, czero, adv, wrap;
	logic                carry;
	logic                accept, move;
	dons_req_t           req;
	dons_rsp_t           rsp;

	always_comb begin
		if (rank_q == 3'd0) rank_eff = 3'd1;
		else if (rank_q > 3'(MAX_RANK)) rank_eff = 3'(MAX_RANK);
		else rank_eff = rank_q;
		for (int k = 0; k < MAX_RANK; k++) begin
			if (size_q[k] == '0) size_eff[k] = SIZE_W'(1);
			else if (size_q[k] > MAX_SIZE) size_eff[k] = MAX_SIZE;
			else size_eff[k] = size_q[k];
			used[k]  = 3'(k) < rank_eff;
			norm[k]  = used[k] & ortho_q[k];
			czero[k] = coord_q[k] == '0;
			wrap[k]  = (SIZE_W'(coord_q[k]) + SIZE_W'(1)) >= size_eff[k];
		end
		// Odometer carry ripples from the fastest axis in use upwards.
		carry = 1'b1;
		for (int k = MAX_RANK - 1; k >= 0; k--) begin
			adv[k] = used[k] & carry;
			if (used[k]) carry = carry & wrap[k];
		end
	end

	assign accept       = sample_valid & !sample_stall;
	assign move         = rsp.done & (!res_valid_q | !result_stall);
	assign sample_stall = busy_q;
	assign cfg_ready    = 1'b1;

	assign req.start = accept;
	assign req.fwd   = fwd_q;
	assign req.x     = sample_in;

	dons_arith #(
		.MAX_RANK (MAX_RANK)
	) u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.norm     (norm),
		.czero    (czero),
		.size_eff (size_eff),
		.ack      (move),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= 3'd1;
			for (int k = 0; k < 4; k++) size_q[k] <= SIZE_W'(1);
			ortho_q     <= '0;
			fwd_q       <= 1'b1;
			for (int k = 0; k < MAX_RANK; k++) coord_q[k] <= '0;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RANK:    rank_q    <= cfg_data[2:0];
					REG_SIZE0:   size_q[0] <= cfg_data;
					REG_SIZE1:   size_q[1] <= cfg_data;
					REG_SIZE2:   size_q[2] <= cfg_data;
					REG_SIZE3:   size_q[3] <= cfg_data;
					REG_ORTHO:   ortho_q   <= cfg_data[3:0];
					REG_FORWARD: fwd_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
				for (int k = 0; k < MAX_RANK; k++) begin
					if (adv[k]) begin
						coord_q[k] <= wrap[k] ? '0 : coord_q[k] + 1'b1;
					end
				end
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (move) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) tend_q <= carry;
		if (move) begin
			sample_out_q <= rsp.y;
			tensor_end_q <= tend_q;
		end
	end

	assign result_valid = res_valid_q;
	assign sample_out   = sample_out_q;
	assign tensor_end   = tensor_end_q;

endmodule
